@@ rtl/awc_pkg.sv @@
package awc_pkg;

  localparam int NUM_STATES      = 16;
  localparam int NUM_LETTERS     = 16;
  localparam int MAX_TRANSITIONS = 64;

  localparam int STATE_W = 4;
  localparam int LETTER_W = 4;
  localparam int MASK_W  = 16;
  localparam int CNT_W   = $clog2(MAX_TRANSITIONS + 1);
  localparam int IDX_W   = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;

  localparam logic [MASK_W-1:0] STATE_MASK =
    (NUM_STATES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NUM_STATES) - 64'd1);

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_BEGIN = 3'd2,
    CMD_FEED  = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [STATE_W-1:0]  src;
    logic [LETTER_W-1:0] letter;
    logic [MASK_W-1:0]   tgt;
  } entry_t;

  function automatic logic [MASK_W-1:0] state_bit(input logic [STATE_W-1:0] s);
    state_bit = (MASK_W'(1) << s) & STATE_MASK;
  endfunction

endpackage

@@ rtl/alternating_automaton_word_check.sv @@
// Clear, begin, query, unused commands and an add with an empty target set go straight to the
// finish state, which loads their result into the output register.
// Add and feed scan the transition memory one entry per cycle through its single read port:
// the result then passes through the finish state into the output register.
// A new request is taken the cycle after its result is loaded; a stalled result holds off the load.
// Synchronous active-low reset empties the table and clears the current set and final mask.
module alternating_automaton_word_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_source_state,
  input  logic [3:0]  in_letter,
  input  logic [15:0] in_target_mask,
  input  logic [3:0]  in_query_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_accepted,
  output logic        out_set_empty
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic [awc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [awc_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  awc_pkg::entry_t              rd_data_r;
  awc_pkg::entry_t              mem [awc_pkg::MAX_TRANSITIONS];
  logic                         mem_we;

  logic [awc_pkg::MASK_W-1:0]   cur_r, cur_nxt;
  logic [awc_pkg::MASK_W-1:0]   final_r, final_nxt;
  logic [awc_pkg::MASK_W-1:0]   next_r, next_nxt;
  logic                         dup_r, dup_nxt;

  logic [2:0]                   cmd_r, cmd_nxt;
  awc_pkg::entry_t              req_r, req_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic                         acc_r, acc_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic                         out_accepted_r, out_accepted_nxt;
  logic                         out_set_empty_r, out_set_empty_nxt;

  logic                         in_acc;
  logic                         more;
  logic [awc_pkg::MASK_W-1:0]   tgt_masked;

  assign in_stall      = (state_r != ST_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign more          = (idx_r < cnt_r);
  assign tgt_masked    = in_target_mask & awc_pkg::STATE_MASK;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_accepted  = out_accepted_r;
  assign out_set_empty = out_set_empty_r;

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    rd_vld_nxt        = rd_vld_r;
    cur_nxt           = cur_r;
    final_nxt         = final_r;
    next_nxt          = next_r;
    dup_nxt           = dup_r;
    cmd_nxt           = cmd_r;
    req_nxt           = req_r;
    status_nxt        = status_r;
    acc_nxt           = acc_r;
    out_valid_nxt     = out_valid_r;
    out_status_nxt    = out_status_r;
    out_accepted_nxt  = out_accepted_r;
    out_set_empty_nxt = out_set_empty_r;
    mem_we            = 1'b0;

    if (cfg_we) begin
      final_nxt = cfg_wdata;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_command;
          req_nxt.src    = in_source_state;
          req_nxt.letter = in_letter;
          req_nxt.tgt    = tgt_masked;
          status_nxt     = awc_pkg::STAT_OK;
          acc_nxt        = 1'b0;
          idx_nxt        = '0;
          rd_vld_nxt     = 1'b0;
          dup_nxt        = 1'b0;
          next_nxt       = '0;
          state_nxt      = ST_FINISH;
          case (in_command)
            awc_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            awc_pkg::CMD_ADD: begin
              if (tgt_masked == '0) begin
                status_nxt = awc_pkg::STAT_EMPTY;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            awc_pkg::CMD_BEGIN: begin
              cur_nxt = final_r & awc_pkg::STATE_MASK;
            end
            awc_pkg::CMD_FEED: begin
              state_nxt = ST_SCAN;
            end
            awc_pkg::CMD_QUERY: begin
              acc_nxt = |(cur_r & awc_pkg::state_bit(in_query_state));
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (more) begin
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          if (cmd_r == awc_pkg::CMD_ADD) begin
            if (rd_data_r == req_r) begin
              dup_nxt = 1'b1;
            end
          end else if (rd_data_r.letter == req_r.letter &&
                       (rd_data_r.tgt & ~cur_r) == '0) begin
            next_nxt = next_r | awc_pkg::state_bit(rd_data_r.src);
          end
        end
        if (!more && !rd_vld_r) begin
          state_nxt = ST_FINISH;
          if (cmd_r == awc_pkg::CMD_ADD) begin
            if (dup_r) begin
              status_nxt = awc_pkg::STAT_DUP;
            end else if (cnt_r == awc_pkg::CNT_W'(awc_pkg::MAX_TRANSITIONS)) begin
              status_nxt = awc_pkg::STAT_FULL;
            end else begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            cur_nxt = next_r;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = status_r;
          out_accepted_nxt  = acc_r;
          out_set_empty_nxt = (cur_r == '0);
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      cur_r       <= '0;
      final_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cur_r       <= cur_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
    next_r          <= next_nxt;
    dup_r           <= dup_nxt;
    cmd_r           <= cmd_nxt;
    req_r           <= req_nxt;
    status_r        <= status_nxt;
    acc_r           <= acc_nxt;
    out_status_r    <= out_status_nxt;
    out_accepted_r  <= out_accepted_nxt;
    out_set_empty_r <= out_set_empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[awc_pkg::IDX_W-1:0]] <= req_r;
    end
    rd_data_r <= mem[idx_r[awc_pkg::IDX_W-1:0]];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= awc_pkg::CNT_W'(awc_pkg::MAX_TRANSITIONS))
    else $error("Entry count exceeds table depth.");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("Request taken while the previous one is still in progress.");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1 || cnt_r == '0))
    else $error("Entry count moved by more than one.");

  a_set_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH || (state_r == ST_IDLE &&
      !(in_acc && in_command == awc_pkg::CMD_BEGIN))) |=> $stable(cur_r))
    else $error("Current set changed outside a begin or feed.");

endmodule

@@ tb/awc_result_checker.sv @@
module awc_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_source_state,
  input  logic [3:0]  in_letter,
  input  logic [15:0] in_target_mask,
  input  logic [3:0]  in_query_state,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        out_accepted,
  input  logic        out_set_empty,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked,
  output int          hits_seen,
  output int          full_seen
);

  typedef struct packed {
    awc_pkg::status_t status;
    logic             accepted;
    logic             set_empty;
  } outcome_t;

  awc_pkg::entry_t            rules [awc_pkg::MAX_TRANSITIONS];
  int                         rule_count;
  logic [awc_pkg::MASK_W-1:0] live_set;
  logic [awc_pkg::MASK_W-1:0] accept_mask;
  outcome_t                   word_outcomes [$];
  int                         mismatches = 0;
  int                         checked = 0;
  int                         hits = 0;
  int                         fulls = 0;

  function automatic logic [awc_pkg::MASK_W-1:0] one_state(
    input logic [awc_pkg::STATE_W-1:0] s);
    return (int'(s) < awc_pkg::NUM_STATES) ? (awc_pkg::MASK_W'(1) << s) : '0;
  endfunction

  task automatic advance_word_state(input logic [2:0] cmd, input logic [3:0] src,
                                    input logic [3:0] letter, input logic [15:0] tgt_in,
                                    input logic [3:0] qs);
    outcome_t                   o;
    awc_pkg::entry_t            cand;
    logic [awc_pkg::MASK_W-1:0] nxt;
    logic                       dup;
    o = '{status: awc_pkg::STAT_OK, accepted: 1'b0, set_empty: 1'b0};
    case (cmd)
      awc_pkg::CMD_CLEAR: begin
        rule_count = 0;
      end
      awc_pkg::CMD_ADD: begin
        cand.src = src;
        cand.letter = letter;
        cand.tgt = tgt_in & awc_pkg::STATE_MASK;
        dup = 1'b0;
        for (int i = 0; i < rule_count; i++)
          if (rules[i] == cand) dup = 1'b1;
        if (cand.tgt == '0) begin
          o.status = awc_pkg::STAT_EMPTY;
        end else if (dup) begin
          o.status = awc_pkg::STAT_DUP;
        end else if (rule_count >= awc_pkg::MAX_TRANSITIONS) begin
          o.status = awc_pkg::STAT_FULL;
        end else begin
          rules[rule_count] = cand;
          rule_count++;
        end
      end
      awc_pkg::CMD_BEGIN: begin
        live_set = accept_mask & awc_pkg::STATE_MASK;
      end
      awc_pkg::CMD_FEED: begin
        nxt = '0;
        for (int i = 0; i < rule_count; i++)
          if (rules[i].letter == letter && (rules[i].tgt & ~live_set) == '0)
            nxt |= one_state(rules[i].src);
        live_set = nxt;
      end
      awc_pkg::CMD_QUERY: begin
        o.accepted = (live_set & one_state(qs)) != '0;
      end
      default: begin
      end
    endcase
    o.set_empty = (live_set == '0);
    word_outcomes.push_back(o);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      rule_count = 0;
      live_set = '0;
      accept_mask = '0;
      word_outcomes.delete();
    end else begin
      if (cfg_we) accept_mask = cfg_wdata;
      if (out_valid && !out_stall) begin
        checked++;
        if (out_accepted) hits++;
        if (out_status == awc_pkg::STAT_FULL) fulls++;
        if (word_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result with no request waiting: status %0d accepted %0b set_empty %0b",
                     out_status, out_accepted, out_set_empty);
        end else begin
          want = word_outcomes.pop_front();
          if (out_status !== want.status || out_accepted !== want.accepted ||
              out_set_empty !== want.set_empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch on result %0d: status %0d/%0d, accepted %0b/%0b, ",
                        "set_empty %0b/%0b (expected/actual)"}, checked,
                       want.status, out_status, want.accepted, out_accepted,
                       want.set_empty, out_set_empty);
          end
        end
      end
      if (in_valid && !in_stall)
        advance_word_state(in_command, in_source_state, in_letter, in_target_mask,
                           in_query_state);
    end
    fail_count <= mismatches;
    outstanding <= word_outcomes.size();
    results_checked <= checked;
    hits_seen <= hits;
    full_seen <= fulls;
  end

endmodule

@@ tb/tb_alternating_automaton_word_check.sv @@
module tb_alternating_automaton_word_check;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          RANDOM_ITEMS   = 1600;
  localparam int          PHASE_ITEMS    = 250;
  localparam int          IDLE_PCT       = 26;
  localparam logic [2:0]  CMD_SPARE_LO   = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [3:0]  in_source_state = '0;
  logic [3:0]  in_letter = '0;
  logic [15:0] in_target_mask = '0;
  logic [3:0]  in_query_state = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_accepted;
  logic        out_set_empty;

  int   fail_count, outstanding, results_checked, hits_seen, full_seen;
  int   requests_sent = 0;
  int   mask_writes = 0;
  int   quiet_cycles = 0;
  logic steady = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  alternating_automaton_word_check dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_source_state(in_source_state), .in_letter(in_letter),
    .in_target_mask(in_target_mask), .in_query_state(in_query_state),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_accepted(out_accepted), .out_set_empty(out_set_empty)
  );

  awc_result_checker word_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_source_state(in_source_state), .in_letter(in_letter),
    .in_target_mask(in_target_mask), .in_query_state(in_query_state),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_accepted(out_accepted), .out_set_empty(out_set_empty),
    .fail_count(fail_count), .outstanding(outstanding),
    .results_checked(results_checked), .hits_seen(hits_seen), .full_seen(full_seen)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] sparse_mask();
    logic [15:0] m;
    m = '0;
    repeat ($urandom_range(1, 3)) m[$urandom_range(0, 15)] = 1'b1;
    return m;
  endfunction

  function automatic logic [3:0] busy_letter();
    return ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] any4();
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic issue_request(input logic [2:0] cmd, input logic [3:0] src,
                               input logic [3:0] letter, input logic [15:0] tgt,
                               input logic [3:0] qs);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_source_state <= src;
    in_letter <= letter;
    in_target_mask <= tgt;
    in_query_state <= qs;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_final_mask(input logic [15:0] value);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mask_writes++;
  endtask

  initial begin
    int          goal, next_phase, steady_from, steady_to, r;
    logic [3:0]  src, letter;
    logic [15:0] tgt, first_tgt;
    logic        have_prev;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_request(awc_pkg::CMD_QUERY, 4'd0, 4'd0, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_FEED, 4'd0, 4'd0, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_ADD, 4'd0, 4'd0, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_ADD, 4'd15, 4'd15, 16'hFFFF, 4'd15);
    issue_request(awc_pkg::CMD_ADD, 4'd15, 4'd15, 16'hFFFF, 4'd15);
    issue_request(awc_pkg::CMD_BEGIN, 4'd0, 4'd0, 16'h0000, 4'd0);
    for (int c = int'(CMD_SPARE_LO); c <= int'(CMD_SPARE_HI); c++)
      issue_request(3'(c), any4(), any4(), 16'($urandom), any4());
    issue_request(awc_pkg::CMD_CLEAR, 4'd0, 4'd0, 16'h0000, 4'd0);
    set_final_mask(16'hFFFF);
    issue_request(awc_pkg::CMD_ADD, 4'd3, 4'd2, 16'h0010, 4'd0);
    issue_request(awc_pkg::CMD_ADD, 4'd5, 4'd2, 16'h0030, 4'd0);
    issue_request(awc_pkg::CMD_ADD, 4'd7, 4'd2, 16'h8000, 4'd0);
    issue_request(awc_pkg::CMD_BEGIN, 4'd0, 4'd0, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_FEED, 4'd0, 4'd2, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_QUERY, 4'd0, 4'd0, 16'h0000, 4'd3);
    issue_request(awc_pkg::CMD_QUERY, 4'd0, 4'd0, 16'h0000, 4'd4);
    issue_request(awc_pkg::CMD_QUERY, 4'd0, 4'd0, 16'h0000, 4'd15);
    issue_request(awc_pkg::CMD_CLEAR, 4'd0, 4'd0, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_QUERY, 4'd0, 4'd0, 16'h0000, 4'd5);
    issue_request(awc_pkg::CMD_FEED, 4'd0, 4'd2, 16'h0000, 4'd0);
    issue_request(awc_pkg::CMD_FEED, 4'd0, 4'd9, 16'h0000, 4'd0);

    goal = requests_sent + RANDOM_ITEMS;
    next_phase = requests_sent + PHASE_ITEMS;
    steady_from = requests_sent + 600;
    steady_to = requests_sent + 950;
    have_prev = 1'b0;
    src = '0;
    letter = '0;
    tgt = '0;
    while (requests_sent < goal) begin
      if (requests_sent >= next_phase) begin
        case (mask_writes % 6)
          1: set_final_mask(16'h8000);
          2: set_final_mask(16'h0001);
          3: set_final_mask(16'h0000);
          4: set_final_mask(16'hFFFF);
          default: set_final_mask(16'($urandom));
        endcase
        next_phase += PHASE_ITEMS;
      end
      steady = (requests_sent >= steady_from) && (requests_sent < steady_to);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        issue_request(awc_pkg::CMD_CLEAR, any4(), any4(), 16'($urandom), any4());
        first_tgt = sparse_mask();
        for (int i = 0; i < awc_pkg::MAX_TRANSITIONS + 2; i++)
          issue_request(awc_pkg::CMD_ADD, 4'(i % awc_pkg::NUM_STATES),
                        4'(i / awc_pkg::NUM_STATES),
                        (i == 0) ? first_tgt : sparse_mask(), any4());
        issue_request(awc_pkg::CMD_ADD, 4'd0, 4'd0, first_tgt, any4());
        issue_request(awc_pkg::CMD_ADD, any4(), any4(), 16'h0000, any4());
      end else if (r < 40) begin
        if ($urandom_range(0, 3) == 0)
          issue_request(awc_pkg::CMD_CLEAR, any4(), any4(), 16'($urandom), any4());
        repeat ($urandom_range(1, 10)) begin
          if (!(have_prev && $urandom_range(0, 4) == 0)) begin
            src = any4();
            letter = busy_letter();
            r = $urandom_range(0, 99);
            tgt = (r < 80) ? sparse_mask() : (r < 92) ? 16'($urandom) : 16'h0000;
            have_prev = 1'b1;
          end
          issue_request(awc_pkg::CMD_ADD, src, letter, tgt, any4());
        end
      end else if (r < 85) begin
        issue_request(awc_pkg::CMD_BEGIN, any4(), any4(), 16'($urandom), any4());
        repeat ($urandom_range(0, 5))
          issue_request(awc_pkg::CMD_FEED, any4(), busy_letter(), 16'($urandom), any4());
        repeat ($urandom_range(1, 4))
          issue_request(awc_pkg::CMD_QUERY, any4(), any4(), 16'($urandom), any4());
      end else begin
        repeat ($urandom_range(1, 5))
          issue_request(3'($urandom_range(0, 7)), any4(), any4(), 16'($urandom), any4());
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (80) @(posedge clk);
    $display("Sent %0d requests under %0d accepting-state settings; %0d results checked.",
             requests_sent, mask_writes, results_checked);
    $display("Queries answered yes: %0d; adds refused for a full table: %0d.",
             hits_seen, full_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ alternating_automaton_word_check.f @@
rtl/awc_pkg.sv
rtl/alternating_automaton_word_check.sv
tb/awc_result_checker.sv
tb/tb_alternating_automaton_word_check.sv
